// File: src/pts_pkg.sv
// pts_pkg: shared constants, register indexes and controller/datapath types
// for the pan/tilt scan pattern generator; no dependencies
package pts_pkg;

   // angle format, 1/64 degree, signed
   localparam int ANGLE_W   = 15;
   localparam int ANGLE_MAX = 11520;

   // absolute limit differences and step sizes
   localparam int DIFF_W     = 16;
   localparam int STEP_SHIFT = 6;   // tilt step is a whole number of degrees

   // configuration field widths
   localparam int LINES_W  = 5;
   localparam int INTERP_W = 4;
   localparam int SCALE_W  = 9;
   localparam int SCALE_ONE   = 256;
   localparam int SCALE_SHIFT = 8;
   localparam int MIN_LINES   = 2;

   // width used to clamp configuration counts against the parameters
   localparam int CMP_W = 8;
   // width used for saturation of the final angles
   localparam int SAT_W = 48;

   // configuration port
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 15;

   localparam logic [CFG_IDX_W-1:0] REG_SCAN_LINES  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_PAN_LEFT    = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_PAN_RIGHT   = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_TILT_UP     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_TILT_DOWN   = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_INTERP      = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_SCALE = 3'd6;

   // register values after reset
   localparam int RST_SCAN_LINES = 3;
   localparam int RST_PAN_LEFT   = 5760;
   localparam int RST_PAN_RIGHT  = -5760;
   localparam int RST_TILT_UP    = -640;
   localparam int RST_TILT_DOWN  = -3840;
   localparam int RST_INTERP     = 0;
   localparam int RST_SCALE      = 256;

   // parameter defaults
   localparam int DEF_MAX_LINES  = 16;
   localparam int DEF_MAX_INTERP = 15;

   // controller to datapath commands
   typedef struct packed {
      logic restart;     // go back to the first keyframe
      logic div_start;   // launch a division
      logic div_is_pan;  // operand select: pan step when set, tilt step otherwise
      logic load_tstep;  // take the quotient as tilt step
      logic load_pstep;  // take the quotient as pan step
      logic commit;      // load the result register and advance the scan
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: src/pts_ifs.sv
// pts_ifs: request, response and register write channels of the scan generator
// depends on pts_pkg
interface pts_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface pts_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pts_pkg::ANGLE_W-1:0] pan_angle;
   logic signed [pts_pkg::ANGLE_W-1:0] tilt_angle;
   logic                                 pattern_end;

   modport source (output valid, output pan_angle, output tilt_angle,
                   output pattern_end, input ready);
   modport sink   (input valid, input pan_angle, input tilt_angle,
                   input pattern_end, output ready);
endinterface

interface pts_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pts_pkg::CFG_IDX_W-1:0]   index;
   logic [pts_pkg::CFG_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/pts_div.sv
// pts_div: restoring unsigned divider, one quotient bit per cycle
// depends on nothing outside this file
module pts_div #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int COUNT_W = $clog2(NUM_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W:0]     trial;
   logic               fits;

   // one shift and trial subtract per cycle
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         count_in = count_ff + COUNT_W'(1);
         if (count_ff == COUNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/pts_ctrl.sv
// pts_ctrl: sequencer for restart divisions, keyframe arithmetic and commit
// depends on pts_pkg and pts_ifs
module pts_ctrl (
   input  logic                clock,
   input  logic                reset,
   pts_req_if.sink             req_chan,
   output pts_pkg::cmd_type    cmd,
   input  pts_pkg::status_type stat
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV_T = 3'd1;
   localparam logic [2:0] S_DIV_P = 3'd2;
   localparam logic [2:0] S_CALC1 = 3'd3;
   localparam logic [2:0] S_CALC2 = 3'd4;
   localparam logic [2:0] S_CALC3 = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;

   // a new request is taken whenever no keyframe is being worked on
   assign req_chan.ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.restart) begin
                  cmd.restart   = 1'b1;
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV_T;
               end else begin
                  state_in = S_CALC1;
               end
            end
         end
         S_DIV_T: begin
            if (stat.div_done) begin
               cmd.load_tstep = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_is_pan = 1'b1;
               state_in       = S_DIV_P;
            end
         end
         S_DIV_P: begin
            cmd.div_is_pan = 1'b1;
            if (stat.div_done) begin
               cmd.load_pstep = 1'b1;
               state_in       = S_CALC1;
            end
         end
         S_CALC1: state_in = S_CALC2;
         S_CALC2: state_in = S_CALC3;
         S_CALC3: state_in = S_OUT;
         S_OUT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/pts_dp.sv
// pts_dp: registers, scan position state, step divider, keyframe arithmetic
// and result register; depends on pts_pkg, pts_ifs and pts_div
module pts_dp #(
   parameter int MAX_LINES  = pts_pkg::DEF_MAX_LINES,
   parameter int MAX_INTERP = pts_pkg::DEF_MAX_INTERP
) (
   input  logic                 clock,
   input  logic                 reset,
   pts_csr_if.sink              csr_chan,
   pts_rsp_if.source            rsp_chan,
   input  pts_pkg::cmd_type     cmd,
   output pts_pkg::status_type  stat
);
   localparam int ANGLE_W = pts_pkg::ANGLE_W;
   localparam int DIFF_W  = pts_pkg::DIFF_W;
   localparam int CMP_W   = pts_pkg::CMP_W;
   localparam int SAT_W   = pts_pkg::SAT_W;
   localparam int LINE_W  = $clog2(MAX_LINES);
   localparam int IC_W    = $clog2(MAX_INTERP + 2);
   localparam int VIS_W   = LINE_W + 1;
   localparam int DEN_W   = (LINE_W > IC_W) ? LINE_W : IC_W;
   localparam int TQ_W    = DIFF_W - pts_pkg::STEP_SHIFT;
   localparam int TP_W    = LINE_W + DIFF_W;
   localparam int PP_W    = IC_W + DIFF_W;
   localparam int TS_W    = TP_W + 2;
   localparam int PS_W    = PP_W + 2;
   localparam int PSC_W   = PS_W + pts_pkg::SCALE_W + 1;
   localparam int RST_L   = (pts_pkg::RST_SCAN_LINES > MAX_LINES) ?
                            MAX_LINES : pts_pkg::RST_SCAN_LINES;
   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(pts_pkg::ANGLE_MAX);
   localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI;

   function automatic logic signed [ANGLE_W-1:0] sat_angle(
      input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return ANGLE_W'(r);
   endfunction

   // configuration registers
   logic [pts_pkg::LINES_W-1:0]  scan_lines_ff;
   logic signed [ANGLE_W-1:0]    pan_left_ff, pan_right_ff;
   logic signed [ANGLE_W-1:0]    tilt_up_ff, tilt_down_ff;
   logic [pts_pkg::INTERP_W-1:0] interp_ff;
   logic [pts_pkg::SCALE_W-1:0]  scale_ff;

   // scan position
   logic [LINE_W-1:0] line_ff, line_in;
   logic              down_ff, down_in;
   logic              right_ff, right_in;
   logic [IC_W-1:0]   ic_ff, ic_in;
   logic [VIS_W-1:0]  visit_ff, visit_in;
   logic              end_in;

   // step sizes
   logic [TQ_W-1:0]   tstep_ff;
   logic [DIFF_W-1:0] pstep_ff;

   // arithmetic stages
   logic [TP_W-1:0]          tprod_ff;
   logic [PP_W-1:0]          pprod_ff;
   logic signed [TS_W-1:0]   tsum_ff;
   logic signed [PS_W-1:0]   praw_ff, praw_in;
   logic signed [PSC_W-1:0]  pscaled_ff;
   logic signed [PSC_W-1:0]  pan_shift;

   // result register
   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_pan_ff, rsp_tilt_ff;
   logic                      rsp_end_ff;

   // effective line and interpolation counts
   logic [CMP_W-1:0]  lines_eff, lines_raw, interp_raw, interp_eff;
   logic [LINE_W-1:0] lines_m1;
   logic [IC_W-1:0]   n_eff, n_p1;
   logic [VIS_W-1:0]  visit_lim;
   logic [VIS_W-1:0]  visit_inc;
   logic              dir_down;

   // divider operands
   logic signed [DIFF_W-1:0] tdiff, pdiff;
   logic [DIFF_W-1:0]        tabs, pabs;
   logic [DIFF_W-1:0]        div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     div_busy, div_done;
   logic [DIFF_W-1:0]        div_quo;
   logic [DIFF_W-1:0]        tstep_val;
   logic [pts_pkg::SCALE_W-1:0] scale_eff;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_lines_ff <= pts_pkg::LINES_W'(pts_pkg::RST_SCAN_LINES);
         pan_left_ff   <= ANGLE_W'(pts_pkg::RST_PAN_LEFT);
         pan_right_ff  <= ANGLE_W'(pts_pkg::RST_PAN_RIGHT);
         tilt_up_ff    <= ANGLE_W'(pts_pkg::RST_TILT_UP);
         tilt_down_ff  <= ANGLE_W'(pts_pkg::RST_TILT_DOWN);
         interp_ff     <= pts_pkg::INTERP_W'(pts_pkg::RST_INTERP);
         scale_ff      <= pts_pkg::SCALE_W'(pts_pkg::RST_SCALE);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            pts_pkg::REG_SCAN_LINES:   scan_lines_ff <= csr_chan.data[pts_pkg::LINES_W-1:0];
            pts_pkg::REG_PAN_LEFT:     pan_left_ff   <= csr_chan.data;
            pts_pkg::REG_PAN_RIGHT:    pan_right_ff  <= csr_chan.data;
            pts_pkg::REG_TILT_UP:      tilt_up_ff    <= csr_chan.data;
            pts_pkg::REG_TILT_DOWN:    tilt_down_ff  <= csr_chan.data;
            pts_pkg::REG_INTERP:       interp_ff     <= csr_chan.data[pts_pkg::INTERP_W-1:0];
            pts_pkg::REG_BOTTOM_SCALE: scale_ff      <= csr_chan.data[pts_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp line count to the supported range, interpolation count to its maximum
   assign lines_raw  = CMP_W'(scan_lines_ff);
   assign interp_raw = CMP_W'(interp_ff);

   always_comb begin
      if (lines_raw < CMP_W'(pts_pkg::MIN_LINES)) begin
         lines_eff = CMP_W'(pts_pkg::MIN_LINES);
      end else if (lines_raw > CMP_W'(MAX_LINES)) begin
         lines_eff = CMP_W'(MAX_LINES);
      end else begin
         lines_eff = lines_raw;
      end
      if (interp_raw > CMP_W'(MAX_INTERP)) begin
         interp_eff = CMP_W'(MAX_INTERP);
      end else begin
         interp_eff = interp_raw;
      end
   end

   assign lines_m1  = LINE_W'(lines_eff - CMP_W'(1));
   assign n_eff     = IC_W'(interp_eff);
   assign n_p1      = IC_W'(interp_eff + CMP_W'(1));
   assign visit_lim = {lines_m1, 1'b0};

   // step divisions: whole degrees of tilt per line, pan per interpolation slot
   assign tdiff = DIFF_W'(tilt_up_ff) - DIFF_W'(tilt_down_ff);
   assign pdiff = DIFF_W'(pan_left_ff) - DIFF_W'(pan_right_ff);
   assign tabs  = tdiff[DIFF_W-1] ? DIFF_W'(-tdiff) : DIFF_W'(tdiff);
   assign pabs  = pdiff[DIFF_W-1] ? DIFF_W'(-pdiff) : DIFF_W'(pdiff);

   assign div_num = cmd.div_is_pan ? pabs : (tabs >> pts_pkg::STEP_SHIFT);
   assign div_den = cmd.div_is_pan ? DEN_W'(n_p1) : DEN_W'(lines_m1);

   pts_div #(
      .NUM_W (DIFF_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tstep_ff <= '0;
         pstep_ff <= '0;
      end else begin
         if (cmd.load_tstep) tstep_ff <= div_quo[TQ_W-1:0];
         if (cmd.load_pstep) pstep_ff <= div_quo;
      end
   end

   assign tstep_val = {tstep_ff, {pts_pkg::STEP_SHIFT{1'b0}}};

   // scan position advance
   assign visit_inc = visit_ff + VIS_W'(1);
   assign dir_down  = (line_ff >= lines_m1) ? 1'b1 :
                      (line_ff == '0)       ? 1'b0 : down_ff;

   always_comb begin
      line_in  = line_ff;
      down_in  = down_ff;
      right_in = right_ff;
      ic_in    = ic_ff;
      visit_in = visit_ff;
      end_in   = 1'b0;
      if (cmd.restart) begin
         line_in  = lines_m1;
         down_in  = 1'b0;
         right_in = 1'b0;
         ic_in    = '0;
         visit_in = '0;
      end else if (cmd.commit) begin
         if (right_ff) begin
            right_in = 1'b0;
            ic_in    = '0;
            if (visit_inc >= visit_lim) begin
               // last keyframe of the pattern, wrap to the top left
               end_in   = 1'b1;
               line_in  = lines_m1;
               down_in  = 1'b0;
               visit_in = '0;
            end else begin
               visit_in = visit_inc;
               down_in  = dir_down;
               line_in  = dir_down ? line_ff - LINE_W'(1) : line_ff + LINE_W'(1);
            end
         end else if (ic_ff != '0) begin
            ic_in = ic_ff - IC_W'(1);
            if (ic_ff == IC_W'(1)) right_in = 1'b1;
         end else if (n_eff != '0) begin
            ic_in = n_p1;
         end else begin
            right_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= LINE_W'(RST_L - 1);
         down_ff  <= 1'b0;
         right_ff <= 1'b0;
         ic_ff    <= '0;
         visit_ff <= '0;
      end else begin
         line_ff  <= line_in;
         down_ff  <= down_in;
         right_ff <= right_in;
         ic_ff    <= ic_in;
         visit_ff <= visit_in;
      end
   end

   // stage 1: products of position and step
   // stage 2: offsets, pan source select
   // stage 3: bottom line pan scaling
   assign scale_eff = (line_ff != '0) ? pts_pkg::SCALE_W'(pts_pkg::SCALE_ONE) :
                      (scale_ff > pts_pkg::SCALE_W'(pts_pkg::SCALE_ONE)) ?
                      pts_pkg::SCALE_W'(pts_pkg::SCALE_ONE) : scale_ff;

   always_comb begin
      if (right_ff) begin
         praw_in = PS_W'(pan_right_ff);
      end else if (ic_ff != '0) begin
         praw_in = PS_W'(pan_right_ff) + $signed({2'b00, pprod_ff});
      end else begin
         praw_in = PS_W'(pan_left_ff);
      end
   end

   always_ff @(posedge clock) begin
      tprod_ff   <= TP_W'(line_ff) * TP_W'(tstep_val);
      pprod_ff   <= PP_W'(ic_ff) * PP_W'(pstep_ff);
      tsum_ff    <= TS_W'(tilt_down_ff) + $signed({2'b00, tprod_ff});
      praw_ff    <= praw_in;
      pscaled_ff <= PSC_W'(praw_ff) * PSC_W'($signed({1'b0, scale_eff}));
   end

   // floor division by 256 of the scaled pan
   assign pan_shift = pscaled_ff >>> pts_pkg::SCALE_SHIFT;

   // result register, free when empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         rsp_pan_ff  <= sat_angle(SAT_W'(pan_shift));
         rsp_tilt_ff <= sat_angle(SAT_W'(tsum_ff));
         rsp_end_ff  <= end_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pan_angle   = rsp_pan_ff;
   assign rsp_chan.tilt_angle  = rsp_tilt_ff;
   assign rsp_chan.pattern_end = rsp_end_ff;

   assign stat.div_done = div_done;
   assign stat.out_free = !rsp_valid_ff || rsp_chan.ready;

   // checks
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("result committed over a pending response");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("division launched while divider busy");

   a_ic_range: assert property (@(posedge clock) disable iff (reset)
      ic_ff <= IC_W'(MAX_INTERP + 1))
      else $error("interpolation counter out of range");

   a_end_wrap: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && end_in) |=>
      (visit_ff == '0 && !right_ff && ic_ff == '0 && rsp_valid_ff && rsp_end_ff))
      else $error("pattern end without wrap to first keyframe");

endmodule

// File: src/pan_tilt_scan_pattern_generator_unit.sv
// Pan/tilt zig-zag scan keyframe generator: one keyframe per request, top line
// left edge first, bouncing between top and bottom lines. A request that only
// advances passes S_CALC1, S_CALC2 and S_CALC3 and then loads the response register
// in S_OUT once it is free. A restart request first runs two 16-step divisions on
// one shared bit-serial divider (tilt step, then pan step). One request is in
// work at a time; a new one is taken while the previous response still waits.
// Register writes are accepted in every cycle and must only happen while idle.
// depends on pts_pkg, pts_ifs, pts_ctrl, pts_dp
module pan_tilt_scan_pattern_generator_unit #(
   parameter int MAX_LINES  = pts_pkg::DEF_MAX_LINES,
   parameter int MAX_INTERP = pts_pkg::DEF_MAX_INTERP
) (
   input  logic       clock,
   input  logic       reset,
   pts_req_if.sink    req_chan,
   pts_rsp_if.source  rsp_chan,
   pts_csr_if.sink    csr_chan
);
   pts_pkg::cmd_type    cmd;
   pts_pkg::status_type stat;

   // sequencer
   pts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

   // arithmetic, state and response register
   pts_dp #(
      .MAX_LINES  (MAX_LINES),
      .MAX_INTERP (MAX_INTERP)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

// File: tb/pts_keyframe_checker.sv
`timescale 1ns / 100ps
// pts_keyframe_checker: follows register writes, predicts one scan keyframe per
// accepted request and compares it with the responses in order
// depends on pts_pkg and pts_ifs
module pts_keyframe_checker (
   input  logic clock,
   input  logic reset,
   pts_req_if   req_mon,
   pts_rsp_if   rsp_mon,
   pts_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);
   localparam int ANGLE_W      = pts_pkg::ANGLE_W;
   localparam int ANGLE_MAX    = pts_pkg::ANGLE_MAX;
   localparam int LINES_W      = pts_pkg::LINES_W;
   localparam int INTERP_W     = pts_pkg::INTERP_W;
   localparam int SCALE_W      = pts_pkg::SCALE_W;
   localparam int SCALE_ONE    = pts_pkg::SCALE_ONE;
   localparam int SCALE_SHIFT  = pts_pkg::SCALE_SHIFT;
   localparam int MIN_LINES    = pts_pkg::MIN_LINES;
   localparam int LINES_LIMIT  = pts_pkg::DEF_MAX_LINES;
   localparam int INTERP_LIMIT = pts_pkg::DEF_MAX_INTERP;
   localparam int DEGREE       = 1 << pts_pkg::STEP_SHIFT;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic signed [ANGLE_W-1:0] pan;
      logic signed [ANGLE_W-1:0] tilt;
      logic                      last;
   } keyframe_type;

   keyframe_type expected_keyframes[$];

   // register copy
   logic [LINES_W-1:0]        lines_reg;
   logic signed [ANGLE_W-1:0] pan_left_reg;
   logic signed [ANGLE_W-1:0] pan_right_reg;
   logic signed [ANGLE_W-1:0] tilt_up_reg;
   logic signed [ANGLE_W-1:0] tilt_down_reg;
   logic [INTERP_W-1:0]       interp_reg;
   logic [SCALE_W-1:0]        scale_reg;

   // scan position and step sizes
   logic [3:0]  line_no;
   logic        moving_down;
   logic        at_right;
   logic [4:0]  interp_cnt;
   logic [5:0]  visit_cnt;
   logic [14:0] tilt_step;
   logic [14:0] pan_step;

   function automatic int active_lines();
      int l;
      l = lines_reg;
      if (l < MIN_LINES) l = MIN_LINES;
      if (l > LINES_LIMIT) l = LINES_LIMIT;
      return l;
   endfunction

   function automatic int active_interp();
      return (interp_reg > INTERP_LIMIT) ? INTERP_LIMIT : int'(interp_reg);
   endfunction

   function automatic int clamp_angle(int v);
      if (v > ANGLE_MAX) return ANGLE_MAX;
      if (v < -ANGLE_MAX) return -ANGLE_MAX;
      return v;
   endfunction

   // back to the left edge of the top line
   function automatic void rewind_scan();
      line_no     = 4'(active_lines() - 1);
      moving_down = 1'b0;
      at_right    = 1'b0;
      interp_cnt  = '0;
      visit_cnt   = '0;
   endfunction

   // keyframe for one request, then step the scan position
   function automatic keyframe_type predict_keyframe(logic restart);
      keyframe_type kf;
      int lines;
      int n;
      int span;
      int pan;
      int tilt;
      int scale;
      kf.last = 1'b0;
      // restart derives both step sizes from the current limits
      if (restart) begin
         rewind_scan();
         span = int'(tilt_up_reg) - int'(tilt_down_reg);
         if (span < 0) span = -span;
         tilt_step = 15'((span / (DEGREE * (active_lines() - 1))) * DEGREE);
         span = int'(pan_left_reg) - int'(pan_right_reg);
         if (span < 0) span = -span;
         pan_step = 15'(span / (active_interp() + 1));
      end
      lines = active_lines();
      n     = active_interp();
      tilt  = int'(tilt_down_reg) + int'(line_no) * int'(tilt_step);

      if (at_right) begin
         pan = pan_right_reg;
      end else if (interp_cnt != 0) begin
         pan = int'(pan_right_reg) + int'(interp_cnt) * int'(pan_step);
      end else begin
         pan = pan_left_reg;
      end

      // bottom line pan is scaled, rounding toward minus infinity
      if (line_no == 0) begin
         scale = (scale_reg > SCALE_ONE) ? SCALE_ONE : int'(scale_reg);
         pan   = (pan * scale) >>> SCALE_SHIFT;
      end

      // left point, interpolated points high to low, right point, next line
      if (at_right) begin
         at_right   = 1'b0;
         interp_cnt = '0;
         visit_cnt  = visit_cnt + 1'b1;
         if (int'(visit_cnt) >= 2 * (lines - 1)) begin
            kf.last = 1'b1;
            rewind_scan();
         end else begin
            if (int'(line_no) >= lines - 1) moving_down = 1'b1;
            else if (line_no == 0) moving_down = 1'b0;
            if (moving_down) line_no = line_no - 1'b1;
            else line_no = line_no + 1'b1;
         end
      end else if (interp_cnt != 0) begin
         interp_cnt = interp_cnt - 1'b1;
         if (interp_cnt == 0) at_right = 1'b1;
      end else if (n > 0) begin
         interp_cnt = 5'(n + 1);
      end else begin
         at_right = 1'b1;
      end

      kf.pan  = ANGLE_W'(clamp_angle(pan));
      kf.tilt = ANGLE_W'(clamp_angle(tilt));
      return kf;
   endfunction

   always @(posedge clock) begin
      keyframe_type want;
      keyframe_type fresh;
      if (reset) begin
         lines_reg     = LINES_W'(pts_pkg::RST_SCAN_LINES);
         pan_left_reg  = ANGLE_W'(pts_pkg::RST_PAN_LEFT);
         pan_right_reg = ANGLE_W'(pts_pkg::RST_PAN_RIGHT);
         tilt_up_reg   = ANGLE_W'(pts_pkg::RST_TILT_UP);
         tilt_down_reg = ANGLE_W'(pts_pkg::RST_TILT_DOWN);
         interp_reg    = INTERP_W'(pts_pkg::RST_INTERP);
         scale_reg     = SCALE_W'(pts_pkg::RST_SCALE);
         tilt_step     = '0;
         pan_step      = '0;
         rewind_scan();
         expected_keyframes.delete();
      end else begin
         // register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               pts_pkg::REG_SCAN_LINES:   lines_reg     = csr_mon.data[LINES_W-1:0];
               pts_pkg::REG_PAN_LEFT:     pan_left_reg  = csr_mon.data[ANGLE_W-1:0];
               pts_pkg::REG_PAN_RIGHT:    pan_right_reg = csr_mon.data[ANGLE_W-1:0];
               pts_pkg::REG_TILT_UP:      tilt_up_reg   = csr_mon.data[ANGLE_W-1:0];
               pts_pkg::REG_TILT_DOWN:    tilt_down_reg = csr_mon.data[ANGLE_W-1:0];
               pts_pkg::REG_INTERP:       interp_reg    = csr_mon.data[INTERP_W-1:0];
               pts_pkg::REG_BOTTOM_SCALE: scale_reg     = csr_mon.data[SCALE_W-1:0];
               default: ;
            endcase
         end

         // response against the oldest outstanding keyframe
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_keyframes.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: unexpected response pan %0d tilt %0d end %0b",
                           $realtime, rsp_mon.pan_angle, rsp_mon.tilt_angle,
                           rsp_mon.pattern_end);
            end else begin
               want = expected_keyframes.pop_front();
               if (want.pan !== rsp_mon.pan_angle || want.tilt !== rsp_mon.tilt_angle ||
                   want.last !== rsp_mon.pattern_end) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display({"%0t: keyframe mismatch, expected pan %0d tilt %0d end %0b,",
                               " got pan %0d tilt %0d end %0b"},
                              $realtime, want.pan, want.tilt, want.last,
                              rsp_mon.pan_angle, rsp_mon.tilt_angle, rsp_mon.pattern_end);
               end
            end
         end

         // accepted request
         if (req_mon.valid && req_mon.ready) begin
            fresh = predict_keyframe(req_mon.restart);
            expected_keyframes = {expected_keyframes, fresh};
         end
      end
      pending = expected_keyframes.size();
   end

endmodule

// File: tb/tb_pan_tilt_scan_pattern_generator_unit.sv
`timescale 1ns / 100ps
// tb_pan_tilt_scan_pattern_generator_unit: clock, reset, register setup and keyframe
// requests with random idling on both sides; the verdict comes from the checker
// depends on pts_pkg, pts_ifs, pts_keyframe_checker and the generator
module tb_pan_tilt_scan_pattern_generator_unit;
   localparam int ANGLE_W      = pts_pkg::ANGLE_W;
   localparam int ANGLE_MAX    = pts_pkg::ANGLE_MAX;
   localparam int MIN_LINES    = pts_pkg::MIN_LINES;
   localparam int SCALE_ONE    = pts_pkg::SCALE_ONE;
   localparam int ITEM_TARGET  = 1400;
   localparam int DRAIN_CYCLES = 50;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_ITEMS   = 40;
   localparam int TIMEOUT_NS   = 5_000_000;
   localparam int FIELD_MIN    = -(1 << (ANGLE_W - 1));
   localparam int FIELD_MAX    = (1 << (ANGLE_W - 1)) - 1;

   logic clock = 1'b0;
   logic reset;
   logic recv_hold;
   int   fail_count;
   int   pending;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   sent;

   pts_req_if req_chan ();
   pts_rsp_if rsp_chan ();
   pts_csr_if csr_chan ();

   pan_tilt_scan_pattern_generator_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   pts_keyframe_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // response side, random back-pressure plus the long hold-off
   always @(negedge clock) begin
      if (reset || recv_hold) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one request after random idle cycles; valid stays high on return
   task automatic send_request(logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid   = 1'b0;
         req_chan.restart = 1'($urandom_range(1));
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.restart = restart;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic write_reg(logic [pts_pkg::CFG_IDX_W-1:0] reg_index, int value);
      csr_chan.valid = 1'b1;
      csr_chan.index = reg_index;
      csr_chan.data  = pts_pkg::CFG_DATA_W'(value);
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // every register, then the write channel goes quiet
   task automatic load_setting(int lines, int left, int right, int up, int down,
                               int interp, int scale);
      write_reg(pts_pkg::REG_SCAN_LINES, lines);
      write_reg(pts_pkg::REG_PAN_LEFT, left);
      write_reg(pts_pkg::REG_PAN_RIGHT, right);
      write_reg(pts_pkg::REG_TILT_UP, up);
      write_reg(pts_pkg::REG_TILT_DOWN, down);
      write_reg(pts_pkg::REG_INTERP, interp);
      write_reg(pts_pkg::REG_BOTTOM_SCALE, scale);
      csr_chan.valid = 1'b0;
   endtask

   // stop offering requests until every response is in
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly inside the legal angle range, sometimes the field edges
   function automatic int rand_angle();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return int'($urandom_range(FIELD_MAX - FIELD_MIN)) + FIELD_MIN;
      if (pick == 1) begin
         case ($urandom_range(3))
            0:       return FIELD_MIN;
            1:       return FIELD_MAX;
            2:       return -ANGLE_MAX;
            default: return ANGLE_MAX;
         endcase
      end
      return int'($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX;
   endfunction

   task automatic load_random_setting();
      int pick;
      int lines;
      int interp;
      int scale;
      pick = $urandom_range(9);
      if (pick == 0) lines = $urandom_range((1 << pts_pkg::LINES_W) - 1);
      else if (pick == 1) lines = pts_pkg::DEF_MAX_LINES;
      else lines = $urandom_range(6, MIN_LINES);
      if ($urandom_range(4) == 0) interp = $urandom_range((1 << pts_pkg::INTERP_W) - 1);
      else interp = $urandom_range(3);
      pick = $urandom_range(9);
      if (pick < 2) scale = $urandom_range((1 << pts_pkg::SCALE_W) - 1);
      else if (pick == 2) scale = SCALE_ONE;
      else if (pick == 3) scale = 0;
      else scale = $urandom_range(SCALE_ONE);
      load_setting(lines, rand_angle(), rand_angle(), rand_angle(), rand_angle(), interp, scale);
   endtask

   // a run of keyframe requests, normally opened by a restart
   task automatic run_segment(int count);
      logic opener;
      wait_idle();
      opener = ($urandom_range(9) != 0);
      case ($urandom_range(7))
         0: begin
            // shrink the line count under a running pattern
            write_reg(pts_pkg::REG_SCAN_LINES, $urandom_range(4, MIN_LINES));
            csr_chan.valid = 1'b0;
            opener = 1'b0;
         end
         1: opener = 1'b0;
         default: load_random_setting();
      endcase
      send_request(opener);
      repeat (count - 1) send_request($urandom_range(49) == 0);
   endtask

   initial begin
      int mode;
      int goal;
      reset            = 1'b1;
      recv_hold        = 1'b0;
      sent             = 0;
      req_chan.valid   = 1'b0;
      req_chan.restart = 1'b0;
      rsp_chan.ready   = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = '0;
      csr_chan.data    = '0;
      send_idle_pct    = 6;
      recv_idle_pct    = 83;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // reset setting with steps still zero, past one pattern end, then a restart
      repeat (9) send_request(1'b0);
      send_request(1'b1);
      repeat (4) send_request(1'b0);

      // widest limits, line count clamped high, full interpolation, scale above one
      wait_idle();
      load_setting(31, FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MIN, 15, 511);
      send_request(1'b1);
      repeat (4) send_request(1'b0);

      // line count clamped low, widest pan limits, equal tilt limits, zero scale on the bottom line
      wait_idle();
      load_setting(0, FIELD_MAX, FIELD_MIN, 0, 0, 2, 0);
      send_request(1'b1);
      repeat (10) send_request(1'b0);

      // random runs: sender rarely idle, then receiver rarely idle, then no idling
      for (mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 1) ? 83 : (mode == 0) ? 6 : 0;
         recv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 6 : 0;
         goal = sent + (ITEM_TARGET - sent) / (3 - mode);
         if (mode == 2) begin
            // receiver holds off while requests keep coming
            wait_idle();
            fork
               begin
                  @(posedge clock);
                  recv_hold = 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  recv_hold = 1'b0;
               end
            join_none
            send_request(1'b1);
            repeat (HOLD_ITEMS - 1) send_request($urandom_range(49) == 0);
         end
         while (sent < goal) run_segment($urandom_range(60, 10));
      end

      wait_idle();
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule
